[hw/rtl/page_frame_refcount_allocator_macros.svh]
// Assertion macros used by the back end of the page frame allocator RTL
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PFRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define PFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pfra_pkg.sv]
// Shared types and constants of the page frame allocator
`default_nettype none

package pfra_pkg;

    // Defaults of the top level parameters
    localparam int NUM_FRAMES_DEF  = 512;
    localparam int FRAME_SHIFT_DEF = 12;

    // Field widths
    localparam int ADDR_W  = 24;
    localparam int OWNER_W = 8;
    localparam int FADDR_W = 21;
    localparam int COUNT_W = 7;

    // Free bitmap word layout
    localparam int WORD_W     = 32;
    localparam int WORD_BIT_W = $clog2(WORD_W);

    // Frame index carried between front and back, wide enough for 65536 frames
    localparam int FIDX_MAX_W = 16;

    localparam logic [COUNT_W-1:0] REFCOUNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_ASSIGN  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_SHARE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    // Classified item handed from front to back
    typedef struct packed {
        opcode_t                     op;
        logic                        bad_addr;
        logic [FIDX_MAX_W-1:0]       frame_idx;
        logic signed [OWNER_W-1:0]   owner;
    } cmd_t;

    // Control from back to front
    typedef struct packed {
        logic init_done;
        logic cmd_pop;
    } back_ctrl_t;

    // One result item
    typedef struct packed {
        status_t                     status;
        logic [FADDR_W-1:0]          frame_address;
        logic signed [OWNER_W-1:0]   frame_owner;
        logic [COUNT_W-1:0]          frame_refcount;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/pfra_ram.sv]
// Generic single write port RAM with registered read
`default_nettype none

module pfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/pfra_front.sv]
// Front end: accepts items, checks addresses and queues them for the back end
`default_nettype none

module pfra_front #(
    parameter int NUM_FRAMES  = pfra_pkg::NUM_FRAMES_DEF,
    parameter int FRAME_SHIFT = pfra_pkg::FRAME_SHIFT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [1:0]                         opcode,
    input  wire logic [pfra_pkg::ADDR_W-1:0]        page_address,
    input  wire logic signed [pfra_pkg::OWNER_W-1:0] page_owner,
    input  wire pfra_pkg::back_ctrl_t               back_ctrl,
    output logic                                    cmd_valid,
    output pfra_pkg::cmd_t                          cmd
);

    localparam logic [63:0] OFFSET_MASK64 = (64'd1 << FRAME_SHIFT) - 64'd1;

    logic [31:0]      idx_wide;
    logic             misaligned;
    logic             out_of_range;
    pfra_pkg::cmd_t   cmd_in;
    logic             push_ok;

    pfra_pkg::cmd_t   q_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    // Classify the incoming item
    assign idx_wide     = 32'(page_address) >> FRAME_SHIFT;
    assign misaligned   = (page_address & OFFSET_MASK64[pfra_pkg::ADDR_W-1:0]) != '0;
    assign out_of_range = idx_wide >= 32'(NUM_FRAMES);

    always_comb
    begin
        cmd_in.op        = pfra_pkg::opcode_t'(opcode);
        cmd_in.bad_addr  = (cmd_in.op != pfra_pkg::OP_ALLOC) && (misaligned || out_of_range);
        cmd_in.frame_idx = idx_wide[pfra_pkg::FIDX_MAX_W-1:0];
        cmd_in.owner     = page_owner;
    end

    // Hold items off while the queue is full or until the table is cleared
    assign full    = (count_reg == 2'd2) || !back_ctrl.init_done;
    assign push_ok = push && !full;

    assign cmd_valid = count_reg != 2'd0;
    assign cmd       = q_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (back_ctrl.cmd_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push_ok && !back_ctrl.cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push_ok && back_ctrl.cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pfra_back.sv]
// Back end: clears the free bitmap, executes items on the frame tables, queues results
`default_nettype none
`include "page_frame_refcount_allocator_macros.svh"

module pfra_back #(
    parameter int NUM_FRAMES  = pfra_pkg::NUM_FRAMES_DEF,
    parameter int FRAME_SHIFT = pfra_pkg::FRAME_SHIFT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire pfra_pkg::cmd_t        cmd,
    output pfra_pkg::back_ctrl_t       back_ctrl,
    input  wire logic                  pop,
    output logic                       empty,
    output pfra_pkg::result_t          res
);

    localparam int WW         = pfra_pkg::WORD_W;
    localparam int WB         = pfra_pkg::WORD_BIT_W;
    localparam int WORDS      = (NUM_FRAMES + WW - 1) / WW;
    localparam int WORD_IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W      = WORD_IDX_W + WB;
    localparam int ENT_AW     = $clog2(NUM_FRAMES);
    localparam int LAST_BITS  = NUM_FRAMES - (WORDS - 1) * WW;
    localparam logic [63:0]           LAST_MASK64 = (64'd1 << LAST_BITS) - 64'd1;
    localparam logic [WW-1:0]         LAST_MASK   = LAST_MASK64[WW-1:0];
    localparam logic [WORD_IDX_W-1:0] LAST_WORD   = WORD_IDX_W'(WORDS - 1);
    localparam logic [WORD_IDX_W-1:0] WORD_ONE    = WORD_IDX_W'(1);

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_SCAN = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    typedef struct packed {
        logic signed [pfra_pkg::OWNER_W-1:0] owner;
        logic [pfra_pkg::COUNT_W-1:0]        count;
    } entry_t;

    state_t                  state_reg, state_next;
    logic [WORD_IDX_W-1:0]   init_word_reg, init_word_next;
    logic [WORD_IDX_W-1:0]   hint_reg, hint_next;
    logic [WORD_IDX_W-1:0]   scan_word_reg, scan_word_next;
    pfra_pkg::cmd_t          cur_cmd_reg;

    // Table ports
    logic                    bm_we;
    logic [WORD_IDX_W-1:0]   bm_waddr, bm_raddr;
    logic [WW-1:0]           bm_wdata, bm_rdata;
    logic                    ent_we;
    logic [ENT_AW-1:0]       ent_waddr, ent_raddr;
    entry_t                  ent_wdata, ent_rdata;

    // Index decode
    logic [IDX_W-1:0]        in_idx, cur_idx, found_idx, res_idx;
    logic [WORD_IDX_W-1:0]   cur_word;
    logic [WB-1:0]           cur_bit, found_bit;
    logic                    cmd_pop;

    // Execute outcome
    logic                                is_free;
    logic signed [pfra_pkg::OWNER_W-1:0] cur_owner, ex_owner;
    logic [pfra_pkg::COUNT_W-1:0]        cur_count, ex_count;
    pfra_pkg::status_t                   ex_status;
    logic                                ex_ent_we, ex_bm_we, ex_freed;
    logic [WW-1:0]                       ex_word;

    // Result staging
    logic                                res_push, res_pop, res_blank;
    pfra_pkg::status_t                   res_status;
    logic signed [pfra_pkg::OWNER_W-1:0] res_owner;
    logic [pfra_pkg::COUNT_W-1:0]        res_count;
    logic [31:0]                         faddr_wide;
    pfra_pkg::result_t                   res_in;

    pfra_pkg::result_t       out_q_reg [2];
    logic                    out_wr_reg, out_wr_next;
    logic                    out_rd_reg, out_rd_next;
    logic [1:0]              out_count_reg, out_count_next;

    // Free bitmap, one bit per frame, set when the frame is free
    pfra_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Owner and count per frame, meaningful only while the frame is busy
    pfra_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_FRAMES)
    ) u_entries (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign in_idx    = cmd.frame_idx[IDX_W-1:0];
    assign cur_idx   = cur_cmd_reg.frame_idx[IDX_W-1:0];
    assign cur_word  = cur_idx[IDX_W-1:WB];
    assign cur_bit   = cur_idx[WB-1:0];
    assign found_idx = {scan_word_reg, found_bit};

    // Find the lowest free frame in the word just read
    always_comb
    begin
        found_bit = '0;
        for (int b = WW - 1; b >= 0; b--)
        begin
            if (bm_rdata[b])
            begin
                found_bit = WB'(b);
            end
        end
    end

    // A free frame always has owner 0 and count 0
    assign is_free   = bm_rdata[cur_bit];
    assign cur_owner = is_free ? '0 : ent_rdata.owner;
    assign cur_count = is_free ? '0 : ent_rdata.count;

    // Work out assign, release and share on the addressed frame
    always_comb
    begin
        ex_status = pfra_pkg::ST_OK;
        ex_owner  = cur_owner;
        ex_count  = cur_count;
        ex_ent_we = 1'b0;
        ex_bm_we  = 1'b0;
        ex_freed  = 1'b0;
        ex_word   = bm_rdata;
        case (cur_cmd_reg.op)
            pfra_pkg::OP_ASSIGN:
            begin
                if (!is_free)
                begin
                    ex_status = pfra_pkg::ST_BUSY;
                end
                else
                begin
                    ex_owner          = cur_cmd_reg.owner;
                    ex_count          = 7'd1;
                    ex_ent_we         = 1'b1;
                    ex_bm_we          = 1'b1;
                    ex_word[cur_bit]  = 1'b0;
                end
            end
            pfra_pkg::OP_RELEASE:
            begin
                if (!is_free)
                begin
                    ex_count  = cur_count - 7'd1;
                    ex_ent_we = 1'b1;
                    if (cur_count == 7'd1)
                    begin
                        ex_owner         = '0;
                        ex_bm_we         = 1'b1;
                        ex_word[cur_bit] = 1'b1;
                        ex_freed         = 1'b1;
                    end
                end
            end
            pfra_pkg::OP_SHARE:
            begin
                if (is_free)
                begin
                    ex_count         = 7'd1;
                    ex_ent_we        = 1'b1;
                    ex_bm_we         = 1'b1;
                    ex_word[cur_bit] = 1'b0;
                end
                else if (cur_count != pfra_pkg::REFCOUNT_MAX)
                begin
                    ex_count  = cur_count + 7'd1;
                    ex_ent_we = 1'b1;
                end
            end
            default:
            begin
                ex_status = pfra_pkg::ST_OK;
            end
        endcase
    end

    // Sequence clearing, scanning and execution
    always_comb
    begin
        state_next     = state_reg;
        init_word_next = init_word_reg;
        hint_next      = hint_reg;
        scan_word_next = scan_word_reg;
        cmd_pop        = 1'b0;
        bm_we          = 1'b0;
        bm_waddr       = cur_word;
        bm_wdata       = ex_word;
        bm_raddr       = scan_word_reg;
        ent_we         = 1'b0;
        ent_waddr      = cur_idx[ENT_AW-1:0];
        ent_wdata      = '{owner: ex_owner, count: ex_count};
        ent_raddr      = in_idx[ENT_AW-1:0];
        res_push       = 1'b0;
        res_blank      = 1'b0;
        res_status     = ex_status;
        res_idx        = cur_idx;
        res_owner      = ex_owner;
        res_count      = ex_count;
        case (state_reg)
            S_INIT:
            begin
                bm_we          = 1'b1;
                bm_waddr       = init_word_reg;
                bm_wdata       = (init_word_reg == LAST_WORD) ? LAST_MASK : '1;
                init_word_next = init_word_reg + WORD_ONE;
                if (init_word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid && (out_count_reg != 2'd2))
                begin
                    cmd_pop = 1'b1;
                    if (cmd.bad_addr)
                    begin
                        res_push   = 1'b1;
                        res_status = pfra_pkg::ST_BAD_ADDR;
                        res_blank  = 1'b1;
                    end
                    else if (cmd.op == pfra_pkg::OP_ALLOC)
                    begin
                        scan_word_next = hint_reg;
                        bm_raddr       = hint_reg;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        bm_raddr   = in_idx[IDX_W-1:WB];
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                if (|bm_rdata)
                begin
                    bm_we               = 1'b1;
                    bm_waddr            = scan_word_reg;
                    bm_wdata            = bm_rdata;
                    bm_wdata[found_bit] = 1'b0;
                    ent_we              = 1'b1;
                    ent_waddr           = found_idx[ENT_AW-1:0];
                    ent_wdata           = '{owner: cur_cmd_reg.owner, count: 7'd1};
                    hint_next           = scan_word_reg;
                    res_push            = 1'b1;
                    res_status          = pfra_pkg::ST_OK;
                    res_idx             = found_idx;
                    res_owner           = cur_cmd_reg.owner;
                    res_count           = 7'd1;
                    state_next          = S_IDLE;
                end
                else if (scan_word_reg == LAST_WORD)
                begin
                    res_push   = 1'b1;
                    res_status = pfra_pkg::ST_NO_FREE;
                    res_blank  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_word_next = scan_word_reg + WORD_ONE;
                    bm_raddr       = scan_word_reg + WORD_ONE;
                end
            end
            S_EXEC:
            begin
                bm_we    = ex_bm_we;
                ent_we   = ex_ent_we;
                res_push = 1'b1;
                if (ex_freed && (cur_word < hint_reg))
                begin
                    hint_next = cur_word;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign back_ctrl.init_done = state_reg != S_INIT;
    assign back_ctrl.cmd_pop   = cmd_pop;

    // Build the result item
    assign faddr_wide = 32'(res_idx) << FRAME_SHIFT;

    always_comb
    begin
        res_in.status         = res_status;
        res_in.frame_address  = res_blank ? '0 : faddr_wide[pfra_pkg::FADDR_W-1:0];
        res_in.frame_owner    = res_blank ? '0 : res_owner;
        res_in.frame_refcount = res_blank ? '0 : res_count;
    end

    // Advance the result queue
    assign empty   = out_count_reg == 2'd0;
    assign res_pop = pop && !empty;
    assign res     = out_q_reg[out_rd_reg];

    always_comb
    begin
        out_wr_next    = res_push ? ~out_wr_reg : out_wr_reg;
        out_rd_next    = res_pop ? ~out_rd_reg : out_rd_reg;
        out_count_next = out_count_reg;
        if (res_push && !res_pop)
        begin
            out_count_next = out_count_reg + 2'd1;
        end
        else if (!res_push && res_pop)
        begin
            out_count_next = out_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_word_reg <= '0;
            hint_reg      <= '0;
            scan_word_reg <= '0;
            out_wr_reg    <= 1'b0;
            out_rd_reg    <= 1'b0;
            out_count_reg <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            init_word_reg <= init_word_next;
            hint_reg      <= hint_next;
            scan_word_reg <= scan_word_next;
            out_wr_reg    <= out_wr_next;
            out_rd_reg    <= out_rd_next;
            out_count_reg <= out_count_next;
        end
    end

    // Hold the item under work and the queued results
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_cmd_reg <= cmd;
        end
        if (res_push)
        begin
            out_q_reg[out_wr_reg] <= res_in;
        end
    end

    `PFRA_ASSERT_SAME(a_res_no_overflow, clk, rst_n, res_push, out_count_reg != 2'd2, "result pushed into full queue")
    `PFRA_ASSERT_NEXT(a_exec_single, clk, rst_n, state_reg == S_EXEC, state_reg == S_IDLE, "execute did not return to idle")
    `PFRA_ASSERT_SAME(a_scan_range, clk, rst_n, state_reg == S_SCAN, scan_word_reg <= LAST_WORD, "scan past last bitmap word")
    `PFRA_ASSERT_NEXT(a_res_count, clk, rst_n, res_push && !res_pop, out_count_reg == $past(out_count_reg) + 2'd1, "result count did not grow")

endmodule

`default_nettype wire

[hw/rtl/page_frame_refcount_allocator.sv]
// Top level of the page frame allocator with owner and reference count
//
//   Channel   Handshake            Fields
//   input     push / full          opcode, page_address, page_owner
//   result    empty / pop          status, frame_address, frame_owner, frame_refcount
//
// After reset the free bitmap is swept one 32-frame word per cycle over ceil(NUM_FRAMES/32)
// words (16 at 512 frames); full stays high during the sweep.
// Assign, release and share read the tables and then update them in the back end.
// Allocate reads one bitmap word after another until it finds a free frame; the scan
// starts at the lowest word that may still hold a free frame.
// A two-entry queue sits on each side; the back end takes no item while the result queue is full.
`default_nettype none

module page_frame_refcount_allocator #(
    parameter int NUM_FRAMES  = pfra_pkg::NUM_FRAMES_DEF,
    parameter int FRAME_SHIFT = pfra_pkg::FRAME_SHIFT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [1:0]                          opcode,
    input  wire logic [pfra_pkg::ADDR_W-1:0]         page_address,
    input  wire logic signed [pfra_pkg::OWNER_W-1:0] page_owner,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [1:0]                               status,
    output logic [pfra_pkg::FADDR_W-1:0]             frame_address,
    output logic signed [pfra_pkg::OWNER_W-1:0]      frame_owner,
    output logic [pfra_pkg::COUNT_W-1:0]             frame_refcount
);

    pfra_pkg::back_ctrl_t back_ctrl;
    pfra_pkg::cmd_t       cmd;
    logic                 cmd_valid;
    pfra_pkg::result_t    res;

    // Accept and classify items
    pfra_front #(
        .NUM_FRAMES  (NUM_FRAMES),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .page_address (page_address),
        .page_owner   (page_owner),
        .back_ctrl    (back_ctrl),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd)
    );

    // Carry items out on the frame tables
    pfra_back #(
        .NUM_FRAMES  (NUM_FRAMES),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .back_ctrl (back_ctrl),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    // Unpack the oldest result item
    assign status         = res.status;
    assign frame_address  = res.frame_address;
    assign frame_owner    = res.frame_owner;
    assign frame_refcount = res.frame_refcount;

endmodule

`default_nettype wire

[bench/page_frame_table_checker.sv]
// Checker for the page frame allocator: predicts each result and compares it
`default_nettype none

module page_frame_table_checker #(
    parameter int NUM_FRAMES  = pfra_pkg::NUM_FRAMES_DEF,
    parameter int FRAME_SHIFT = pfra_pkg::FRAME_SHIFT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire logic                                full,
    input  wire logic [1:0]                          opcode,
    input  wire logic [pfra_pkg::ADDR_W-1:0]         page_address,
    input  wire logic signed [pfra_pkg::OWNER_W-1:0] page_owner,
    input  wire logic                                empty,
    input  wire logic                                pop,
    input  wire logic [1:0]                          status,
    input  wire logic [pfra_pkg::FADDR_W-1:0]        frame_address,
    input  wire logic signed [pfra_pkg::OWNER_W-1:0] frame_owner,
    input  wire logic [pfra_pkg::COUNT_W-1:0]        frame_refcount,
    output int                                       fail_count,
    output int                                       pending,
    output int                                       results_checked,
    output int                                       no_free_seen,
    output int                                       ceiling_seen
);
    import pfra_pkg::*;

    // Shadow copy of the frame table
    logic [COUNT_W-1:0]        frame_count [NUM_FRAMES];
    logic signed [OWNER_W-1:0] frame_holder [NUM_FRAMES];

    result_t frame_results_q [$];
    result_t want;
    result_t got;

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        no_free_seen    = 0;
        ceiling_seen    = 0;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            frame_count[i]  = '0;
            frame_holder[i] = '0;
        end
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what, longint seen, longint wanted);
        $display("MISMATCH at result %0d: %s is %0d, expected %0d",
                 results_checked, what, seen, wanted);
        fail_count++;
    endtask

    // Apply one operation to the shadow table and return the result it gives
    function automatic result_t frame_table_update(opcode_t op,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic signed [OWNER_W-1:0] who);
        result_t     r;
        int unsigned idx;
        bit          found;
        r.status         = ST_OK;
        r.frame_address  = '0;
        r.frame_owner    = '0;
        r.frame_refcount = '0;
        idx   = 32'(addr) >> FRAME_SHIFT;
        found = 1'b0;
        if (op == OP_ALLOC)
        begin
            // Take the lowest free frame
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                if (!found && frame_count[i] == 0)
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (!found)
            begin
                r.status = ST_NO_FREE;
                return r;
            end
            frame_count[idx]  = COUNT_W'(1);
            frame_holder[idx] = who;
        end
        else if ((addr & ((ADDR_W'(1) << FRAME_SHIFT) - 1)) != 0 || idx >= NUM_FRAMES)
        begin
            r.status = ST_BAD_ADDR;
            return r;
        end
        else
        begin
            case (op)
                OP_ASSIGN:
                begin
                    if (frame_count[idx] != 0)
                        r.status = ST_BUSY;
                    else
                    begin
                        frame_count[idx]  = COUNT_W'(1);
                        frame_holder[idx] = who;
                    end
                end
                OP_RELEASE:
                begin
                    if (frame_count[idx] != 0)
                        frame_count[idx] = frame_count[idx] - COUNT_W'(1);
                    if (frame_count[idx] == 0)
                        frame_holder[idx] = '0;
                end
                default:
                begin
                    // Saturate at the ceiling
                    if (frame_count[idx] < REFCOUNT_MAX)
                        frame_count[idx] = frame_count[idx] + COUNT_W'(1);
                end
            endcase
        end
        r.frame_address  = FADDR_W'(idx << FRAME_SHIFT);
        r.frame_owner    = frame_holder[idx];
        r.frame_refcount = frame_count[idx];
        return r;
    endfunction

    // Compare results first, then predict accepted items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (frame_results_q.size() == 0)
                    report_mismatch("result with no item waiting, status", status, 0);
                else
                begin
                    want = frame_results_q.pop_front();
                    if (status != want.status)
                        report_mismatch("status", status, want.status);
                    if (frame_address != want.frame_address)
                        report_mismatch("frame_address", frame_address, want.frame_address);
                    if (frame_owner != want.frame_owner)
                        report_mismatch("frame_owner", longint'(frame_owner),
                                        longint'(want.frame_owner));
                    if (frame_refcount != want.frame_refcount)
                        report_mismatch("frame_refcount", frame_refcount,
                                        want.frame_refcount);
                end
                results_checked <= results_checked + 1;
            end
            if (push && !full)
            begin
                got = frame_table_update(opcode_t'(opcode), page_address, page_owner);
                if (got.status == ST_NO_FREE)
                    no_free_seen <= no_free_seen + 1;
                if (opcode_t'(opcode) == OP_SHARE && got.status == ST_OK
                    && got.frame_refcount == REFCOUNT_MAX)
                    ceiling_seen <= ceiling_seen + 1;
                frame_results_q.push_back(got);
            end
            pending <= frame_results_q.size();
        end
    end

endmodule

`default_nettype wire

[bench/tb_page_frame_refcount_allocator.sv]
// Testbench top for the page frame allocator: stimulus, flow control and verdict
`default_nettype none

module tb_page_frame_refcount_allocator;
    import pfra_pkg::*;

    localparam int FRAMES     = NUM_FRAMES_DEF;
    localparam int SHIFT      = FRAME_SHIFT_DEF;
    localparam int IDLE_LIMIT = 2000;

    logic                      clk;
    logic                      rst_n        = 1'b0;
    logic                      push         = 1'b0;
    logic                      pop          = 1'b0;
    logic [1:0]                opcode       = '0;
    logic [ADDR_W-1:0]         page_address = '0;
    logic signed [OWNER_W-1:0] page_owner   = '0;
    logic                      full;
    logic                      empty;
    logic [1:0]                status;
    logic [FADDR_W-1:0]        frame_address;
    logic signed [OWNER_W-1:0] frame_owner;
    logic [COUNT_W-1:0]        frame_refcount;

    int fail_count;
    int pending;
    int results_checked;
    int no_free_seen;
    int ceiling_seen;

    int items_sent   = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int burst_left   = 0;
    int idle_cycles  = 0;
    int rx_mode      = 0;
    int mode_left    = 0;
    int stall_left   = 0;

    page_frame_refcount_allocator #(
        .NUM_FRAMES  (FRAMES),
        .FRAME_SHIFT (SHIFT)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .page_address   (page_address),
        .page_owner     (page_owner),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .frame_address  (frame_address),
        .frame_owner    (frame_owner),
        .frame_refcount (frame_refcount)
    );

    page_frame_table_checker #(
        .NUM_FRAMES  (FRAMES),
        .FRAME_SHIFT (SHIFT)
    ) frame_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .page_address    (page_address),
        .page_owner      (page_owner),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .frame_address   (frame_address),
        .frame_owner     (frame_owner),
        .frame_refcount  (frame_refcount),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .no_free_seen    (no_free_seen),
        .ceiling_seen    (ceiling_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side: always ready, coin flips, or runs of stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= $urandom_range(2, 0);
                mode_left <= $urandom_range(200, 20);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(1, 0));
                default:
                begin
                    if (stall_left != 0)
                    begin
                        pop        <= 1'b0;
                        stall_left <= stall_left - 1;
                    end
                    else
                    begin
                        pop <= 1'b1;
                        if ($urandom_range(7, 0) == 0)
                            stall_left <= $urandom_range(12, 1);
                    end
                end
            endcase
        end
    end

    // End the run when neither side moves an item for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] frame_base(int idx);
        return ADDR_W'(idx) << SHIFT;
    endfunction

    function automatic logic signed [OWNER_W-1:0] random_owner();
        int v;
        v = int'($urandom_range(129, 0)) - 2;
        return OWNER_W'(v);
    endfunction

    // Mostly aligned frames near the bottom, some noise addresses
    function automatic logic [ADDR_W-1:0] random_address(int hot);
        int r;
        r = $urandom_range(99, 0);
        if (r < 8)
            return ADDR_W'($urandom);
        if (r < 13)
            return frame_base($urandom_range(FRAMES - 1, 0))
                   | ADDR_W'($urandom_range((1 << SHIFT) - 1, 1));
        if (r < 83)
            return frame_base($urandom_range(hot - 1, 0));
        return frame_base($urandom_range(FRAMES - 1, 0));
    endfunction

    // Hand one item over, then idle between bursts
    task automatic issue(opcode_t op, logic [ADDR_W-1:0] addr,
                         logic signed [OWNER_W-1:0] who);
        push         <= 1'b1;
        opcode       <= op;
        page_address <= addr;
        page_owner   <= who;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        op_count[op]++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            if ($urandom_range(9, 0) >= 3)
            begin
                push <= 1'b0;
                repeat ($urandom_range(12, 1)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Hold off the sender until every result has come back
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_mix(int count, int hot);
        int      r;
        opcode_t op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99, 0);
            if (r < 20)
                op = OP_ALLOC;
            else if (r < 40)
                op = OP_ASSIGN;
            else if (r < 70)
                op = OP_RELEASE;
            else
                op = OP_SHARE;
            issue(op, random_address(hot), random_owner());
            if ($urandom_range(149, 0) == 0)
                drain();
        end
    endtask

    initial
    begin
        int sat_frame;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: largest and negative owners, every operation, bad and busy cases
        issue(OP_ALLOC,   '0,                  -8'sd2);
        issue(OP_ALLOC,   '0,                  8'sd127);
        issue(OP_ALLOC,   '0,                  -8'sd1);
        issue(OP_ALLOC,   24'hFFFFFF,          8'sd0);
        issue(OP_ASSIGN,  frame_base(0),       8'sd5);
        issue(OP_ASSIGN,  frame_base(FRAMES - 1), 8'sd1);
        issue(OP_ASSIGN,  frame_base(FRAMES),  8'sd1);
        issue(OP_ASSIGN,  24'hFFF000,          8'sd1);
        issue(OP_ASSIGN,  frame_base(4) | 24'h1, 8'sd1);
        issue(OP_RELEASE, 24'hFFFFFF,          8'sd0);
        issue(OP_SHARE,   24'h000800,          8'sd0);
        issue(OP_SHARE,   frame_base(1),       8'sd0);
        issue(OP_RELEASE, frame_base(1),       8'sd0);
        issue(OP_RELEASE, frame_base(1),       8'sd0);
        issue(OP_RELEASE, frame_base(1),       8'sd0);
        issue(OP_SHARE,   frame_base(10),      8'sd0);
        issue(OP_ALLOC,   '0,                  8'sd42);
        issue(OP_RELEASE, frame_base(10),      8'sd0);
        issue(OP_RELEASE, frame_base(FRAMES - 1), 8'sd0);
        issue(OP_SHARE,   frame_base(0),       8'sd0);
        issue(OP_ASSIGN,  frame_base(4),       -8'sd2);
        issue(OP_ALLOC,   '0,                  8'sd9);
        drain();

        // Random traffic on a small set of frames
        random_mix(360, 32);

        // Push one frame past the count ceiling, then step it back down
        sat_frame = $urandom_range(FRAMES - 1, 0);
        for (int n = 0; n < 130; n++)
            issue(OP_SHARE, frame_base(sat_frame), random_owner());
        for (int n = 0; n < 5; n++)
            issue(OP_RELEASE, frame_base(sat_frame), random_owner());
        drain();

        // Exhaust the table so allocate runs out of frames
        for (int n = 0; n < 530; n++)
            issue(OP_ALLOC, ADDR_W'($urandom), random_owner());
        drain();

        // Fragment the full table and refill the holes
        random_mix(400, FRAMES);
        drain();

        repeat (40) @(posedge clk);

        $display("Drove %0d items: %0d allocate, %0d assign, %0d release, %0d share",
                 items_sent, op_count[OP_ALLOC], op_count[OP_ASSIGN],
                 op_count[OP_RELEASE], op_count[OP_SHARE]);
        $display("Checked %0d results, %0d out of frames, %0d shares at the count ceiling",
                 results_checked, no_free_seen, ceiling_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/pfra_pkg.sv
hw/rtl/pfra_ram.sv
hw/rtl/pfra_front.sv
hw/rtl/pfra_back.sv
hw/rtl/page_frame_refcount_allocator.sv
bench/page_frame_table_checker.sv
bench/tb_page_frame_refcount_allocator.sv
